// ===== rtl/star_pkg.sv =====
`default_nettype none
package star_pkg;

  localparam int DataBits  = 32;
  localparam int AngleBits = 16;
  localparam int CordIters = 30;
  localparam int CordW     = 34;
  localparam int ZW        = 33;
  // T = D*S entries: |s|<=2^31, |d|<=2^15, three terms -> under 2^33, 34 bits signed after /2^15
  localparam int TW        = DataBits + 3;
  localparam int RW        = TW + 3;
  localparam logic signed [CordW-1:0] CordGain = CordW'(652032874);

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef logic signed [DataBits-1:0] data_t;
  typedef logic signed [16:0] coef_t;

  typedef struct packed {
    data_t sxx, sxy, sxz, syy, syz, szz;
  } tensor_t;

  typedef struct packed {
    data_t r11, r12, r13, r21, r22, r23, r31, r32, r33;
  } result_t;

  typedef struct packed {
    coef_t d00, d01, d02, d10, d11, d12, d20, d21, d22;
  } rotm_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t [0:29];
    t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
          32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
          32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
          32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
          32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1};
    return t[i];
  endfunction

  // round-half-up of v/2^15, saturated to Q1.15
  function automatic logic signed [15:0] q15_of(input logic signed [CordW-1:0] v);
    logic signed [CordW-1:0] r;
    r = (v + CordW'(16384)) >>> 15;
    if (r > CordW'(32767)) return 16'sh7fff;
    if (r < -CordW'(32768)) return 16'sh8000;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/star_if.sv =====
`default_nettype none
interface star_in_if;
  logic valid;
  logic ready;
  star_pkg::tensor_t tensor;
  logic [1:0] rot_axis;
  logic [star_pkg::AngleBits-1:0] rot_angle;
  modport source (output valid, tensor, rot_axis, rot_angle, input ready);
  modport sink   (input valid, tensor, rot_axis, rot_angle, output ready);
endinterface

interface star_out_if;
  logic valid;
  logic ready;
  star_pkg::result_t result;
  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface
`default_nettype wire

// ===== rtl/star_cordic.sv =====
`default_nettype none
// Pipelined CORDIC, one iteration per stage, with tensor/axis sideband.
module star_cordic (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire logic [star_pkg::AngleBits-1:0] angle,
  input  wire star_pkg::tensor_t in_tensor,
  input  wire logic [1:0] in_axis,
  output logic out_valid,
  output logic signed [15:0] cos_q,
  output logic signed [15:0] sin_q,
  output star_pkg::tensor_t out_tensor,
  output logic [1:0] out_axis
);
  localparam int N = star_pkg::CordIters;
  localparam int CW = star_pkg::CordW;
  localparam int ZW = star_pkg::ZW;

  logic signed [CW-1:0] x [0:N];
  logic signed [CW-1:0] y [0:N];
  logic signed [ZW-1:0] z [0:N];
  logic neg [0:N];
  logic vld [0:N];
  star_pkg::tensor_t ten [0:N];
  logic [1:0] ax [0:N];

  logic [31:0] th0, th;
  logic [1:0] quad;

  always_comb begin
    th0 = {angle, {(32-star_pkg::AngleBits){1'b0}}};
    quad = th0[31:30];
    th = (quad == 2'd1 || quad == 2'd2) ? th0 - 32'h8000_0000 : th0;
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_valid;
    if (en) begin
      x[0] <= star_pkg::CordGain;
      y[0] <= '0;
      z[0] <= ZW'(signed'(th));
      neg[0] <= (quad == 2'd1 || quad == 2'd2);
      ten[0] <= in_tensor;
      ax[0] <= in_axis;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;
    assign at = ZW'(star_pkg::atan_turn(i));
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else if (en) vld[i+1] <= vld[i];
      if (en) begin
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - dx; y[i+1] <= y[i] + dy; z[i+1] <= z[i] - at;
        end else begin
          x[i+1] <= x[i] + dx; y[i+1] <= y[i] - dy; z[i+1] <= z[i] + at;
        end
        neg[i+1] <= neg[i];
        ten[i+1] <= ten[i];
        ax[i+1] <= ax[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vld[N];
    if (en) begin
      cos_q <= star_pkg::q15_of(neg[N] ? -x[N] : x[N]);
      sin_q <= star_pkg::q15_of(neg[N] ? -y[N] : y[N]);
      out_tensor <= ten[N];
      out_axis <= ax[N];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/star_dot3.sv =====
`default_nettype none
// Registered products then registered rounded sum: round-half-up (a.b)/2^15.
module star_dot3 (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [star_pkg::TW-1:0] a0, a1, a2,
  input  wire star_pkg::coef_t b0, b1, b2,
  output logic signed [star_pkg::RW-1:0] q
);
  localparam int AW = star_pkg::TW;
  localparam int OW = star_pkg::RW;
  localparam int PW = AW + 17;
  logic signed [PW-1:0] p0, p1, p2;
  logic signed [PW+1:0] s;

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= PW'(a0 * b0);
      p1 <= PW'(a1 * b1);
      p2 <= PW'(a2 * b2);
    end
  end

  assign s = (PW+2)'(p0) + (PW+2)'(p1) + (PW+2)'(p2) + (PW+2)'(16384);

  always_ff @(posedge clk) begin
    if (en) q <= OW'(s >>> 15);
  end
endmodule
`default_nettype wire

// ===== rtl/star_matmul.sv =====
`default_nettype none
// T = D*S then R = T*D^T, two dot-product stages of two registers each.
module star_matmul (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire logic signed [15:0] cos_q,
  input  wire logic signed [15:0] sin_q,
  input  wire star_pkg::tensor_t tensor,
  input  wire logic [1:0] axis,
  output logic out_valid,
  output star_pkg::result_t result
);
  localparam int DW = star_pkg::DataBits;
  localparam int TW = star_pkg::TW;
  localparam int RW = star_pkg::RW;

  star_pkg::coef_t c, sn, ns, one;
  star_pkg::coef_t d [0:2][0:2];
  star_pkg::coef_t dr [0:2][0:2];
  star_pkg::coef_t dr2 [0:2][0:2];
  star_pkg::coef_t dr3 [0:2][0:2];
  star_pkg::data_t sm [0:2][0:2];
  star_pkg::data_t smr [0:2][0:2];
  // T entries fit in TW bits; the dot unit output is RW wide
  logic signed [RW-1:0] t [0:2][0:2];
  logic signed [RW-1:0] r [0:2][0:2];
  logic [4:0] vld;
  logic signed [RW-1:0] smax, smin;

  always_comb begin
    c = 17'(cos_q);
    sn = 17'(sin_q);
    ns = -sn;
    one = 17'sd32768;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        d[i][j] = '0;
    unique case (star_pkg::axis_t'(axis))
      star_pkg::AXIS_X: begin
        d[0][0] = one; d[1][1] = c; d[1][2] = ns; d[2][1] = sn; d[2][2] = c;
      end
      star_pkg::AXIS_Y: begin
        d[1][1] = one; d[0][0] = c; d[0][2] = ns; d[2][0] = sn; d[2][2] = c;
      end
      star_pkg::AXIS_Z: begin
        d[2][2] = one; d[0][0] = c; d[0][1] = ns; d[1][0] = sn; d[1][1] = c;
      end
      default: ;
    endcase
    sm[0][0] = tensor.sxx; sm[0][1] = tensor.sxy; sm[0][2] = tensor.sxz;
    sm[1][0] = tensor.sxy; sm[1][1] = tensor.syy; sm[1][2] = tensor.syz;
    sm[2][0] = tensor.sxz; sm[2][1] = tensor.syz; sm[2][2] = tensor.szz;
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[3:0], in_valid};
    if (en) begin
      dr <= d; smr <= sm; dr2 <= dr; dr3 <= dr2;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_t
    for (genvar j = 0; j < 3; j++) begin : g_tj
      star_dot3 u_t (
        .clk(clk), .en(en),
        .a0(TW'(smr[0][j])), .a1(TW'(smr[1][j])), .a2(TW'(smr[2][j])),
        .b0(dr[i][0]), .b1(dr[i][1]), .b2(dr[i][2]),
        .q(t[i][j])
      );
      star_dot3 u_r (
        .clk(clk), .en(en),
        .a0(t[i][0][TW-1:0]), .a1(t[i][1][TW-1:0]), .a2(t[i][2][TW-1:0]),
        .b0(dr3[j][0]), .b1(dr3[j][1]), .b2(dr3[j][2]),
        .q(r[i][j])
      );
    end
  end

  assign smax = RW'({1'b0, {(DW-1){1'b1}}});
  assign smin = RW'(signed'({1'b1, {(DW-1){1'b0}}}));

  function automatic star_pkg::data_t sat(input logic signed [RW-1:0] v);
    if (v > smax) return {1'b0, {(DW-1){1'b1}}};
    if (v < smin) return {1'b1, {(DW-1){1'b0}}};
    return v[DW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vld[4];
    if (en) begin
      result.r11 <= sat(r[0][0]); result.r12 <= sat(r[0][1]);
      result.r13 <= sat(r[0][2]); result.r21 <= sat(r[1][0]);
      result.r22 <= sat(r[1][1]); result.r23 <= sat(r[1][2]);
      result.r31 <= sat(r[2][0]); result.r32 <= sat(r[2][1]);
      result.r33 <= sat(r[2][2]);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/symmetric_tensor_axis_rotation.sv =====
`default_nettype none
// Rotates a symmetric 3x3 tensor (Q16.16) about x, y or z by a binary angle
// and returns the nine entries of D*S*D^T, saturated to 32 bits; axis code 3
// gives all zeros. Fully pipelined: one word in and one word out per cycle
// as long as the sink does not stall; 32 CORDIC stages for sin/cos (angle
// fold, 30 iterations and rounding) and 6 for the two matrix products and
// saturation. The whole pipe advances together whenever the output register
// is empty or being read, so a stalled sink freezes it with nothing lost or repeated.
module symmetric_tensor_axis_rotation (
  input  wire logic clk,
  input  wire logic rst,
  star_in_if.sink   in_ch,
  star_out_if.source out_ch
);
  logic en;
  logic cv;
  logic signed [15:0] cq, sq;
  star_pkg::tensor_t ct;
  logic [1:0] ca;

  // advance when the output slot is free or is being taken
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  star_cordic u_cordic (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_ch.valid), .angle(in_ch.rot_angle),
    .in_tensor(in_ch.tensor), .in_axis(in_ch.rot_axis),
    .out_valid(cv), .cos_q(cq), .sin_q(sq),
    .out_tensor(ct), .out_axis(ca)
  );

  star_matmul u_matmul (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(cv), .cos_q(cq), .sin_q(sq),
    .tensor(ct), .axis(ca),
    .out_valid(out_ch.valid), .result(out_ch.result)
  );
endmodule
`default_nettype wire
